>>> hw/rtl/bignum_short_division_unit_assert.svh
// Assertion macros for the short division unit.
`ifndef BIGNUM_SHORT_DIVISION_UNIT_ASSERT_SVH
`define BIGNUM_SHORT_DIVISION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked outside reset.
`define BSDU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bsdu assertion failed");
// Property checked on every edge, reset included.
`define BSDU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bsdu assertion failed");
`else
`define BSDU_ASSERT(lbl, clk, rst, prop)
`define BSDU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hw/rtl/bsd_pkg.sv
// Shared types and constants of the short division unit.
`default_nettype none
package bsd_pkg;

  // Width of divisor, remainder and the digit ports.
  localparam int unsigned WORD_BITS = 32;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/bignum_short_division_unit.sv
// Top level of the multi-word by single-word short division unit.
// Usage:
//   Dividend digits arrive on the input channel (in_valid/in_ready),
//   most significant first; last_digit marks the final digit of a number.
//   Each digit yields one transaction on the output channel
//   (out_valid/out_ready): quotient digit, remainder so far, is_last and
//   divide_error. The remainder carries to the next digit and clears after
//   a last digit. The divisor is written on the cfg channel; a write clears
//   the carried remainder and is taken only while the unit is idle, with
//   no result pending and no digit offered.
// Sequencing:
//   After acceptance a digit is divided one quotient bit per cycle through
//   the shared compare/subtract step; the done pulse then moves the
//   sequencer to ST_DONE, and the result is loaded into the output register
//   once it is free. A zero divisor goes straight to ST_DONE. One digit is
//   in work at a time and in_ready is high only when idle, so a new digit is
//   not taken before the last one's result is loaded. Reset sets divisor to 1,
//   clears the remainder and drops out_valid; nothing is taken while rst is high.
// A stalled receiver holds the result in the output register; the next
// digit may be accepted and divided meanwhile, and waits for the register.
`default_nettype none
`include "bignum_short_division_unit_assert.svh"
module bignum_short_division_unit #(
  parameter int unsigned DIGIT_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bsd_pkg::WORD_BITS-1:0] divisor_value,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bsd_pkg::WORD_BITS-1:0] digit_in,
  input  wire logic                          last_digit,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bsd_pkg::WORD_BITS-1:0]      quotient_digit,
  output logic [bsd_pkg::WORD_BITS-1:0]      partial_remainder,
  output logic                               is_last,
  output logic                               divide_error
);

  bsd_pkg::state_t state, state_next;

  logic [bsd_pkg::WORD_BITS-1:0] divisor;
  logic [bsd_pkg::WORD_BITS-1:0] run_rem;
  logic                          last_q;
  logic                          err_q;

  logic                          in_fire;
  logic                          cfg_fire;
  logic                          out_free;
  logic                          start;
  logic                          load_out;
  logic [DIGIT_BITS-1:0]         quot;
  logic [bsd_pkg::WORD_BITS-1:0] rem_out;
  bsd_pkg::div_stat_t            stat;

  logic                          err_fields_zero;
  logic                          carry_ok;

  assign in_fire  = in_valid && in_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign out_free = !out_valid || out_ready;

  bsd_divider #(
    .DIGIT_BITS (DIGIT_BITS)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .rem_in  (run_rem),
    .digit   (digit_in[DIGIT_BITS-1:0]),
    .divisor (divisor),
    .quot    (quot),
    .rem_out (rem_out),
    .stat    (stat)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    start      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      bsd_pkg::ST_IDLE: begin
        // Nothing is taken in reset; a divisor write yields to an offered digit.
        in_ready  = !rst;
        cfg_ready = !rst && !out_valid && !in_valid;
        if (in_valid && !rst) begin
          if (divisor == '0) begin
            state_next = bsd_pkg::ST_DONE;
          end else begin
            start      = 1'b1;
            state_next = bsd_pkg::ST_RUN;
          end
        end
      end
      bsd_pkg::ST_RUN: begin
        if (stat.done) begin
          state_next = bsd_pkg::ST_DONE;
        end
      end
      bsd_pkg::ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = bsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bsd_pkg::ST_IDLE;
      end
    endcase
  end

  // Divisor and carried remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= bsd_pkg::WORD_BITS'(1);
      run_rem <= '0;
    end else if (cfg_fire) begin
      divisor <= divisor_value;
      run_rem <= '0;
    end else if (load_out) begin
      run_rem <= (err_q || last_q) ? '0 : rem_out;
    end
  end

  // Per-digit flags captured at acceptance.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      last_q <= last_digit;
      err_q  <= (divisor == '0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      quotient_digit    <= err_q ? '0 : bsd_pkg::WORD_BITS'(quot);
      partial_remainder <= err_q ? '0 : rem_out;
      is_last           <= err_q ? 1'b0 : last_q;
      divide_error      <= err_q;
    end
  end

  // Checks.
  assign err_fields_zero = (quotient_digit == '0) && (partial_remainder == '0) && !is_last;
  assign carry_ok        = (run_rem == '0) || (run_rem < divisor);

  `BSDU_ASSERT(a_accept_leaves_idle, clk, rst, in_fire |=> (state != bsd_pkg::ST_IDLE))
  `BSDU_ASSERT(a_done_only_in_run, clk, rst, stat.done |-> (state == bsd_pkg::ST_RUN))
  `BSDU_ASSERT(a_err_zero_fields, clk, rst, (out_valid && divide_error) |-> err_fields_zero)
  `BSDU_ASSERT(a_rem_below_div, clk, rst, out_valid && !divide_error |-> partial_remainder < divisor)
  `BSDU_ASSERT(a_carry_below_div, clk, rst, (state == bsd_pkg::ST_IDLE) |-> carry_ok)

endmodule
`default_nettype wire

>>> hw/rtl/bsd_div_step.sv
// One restoring-division step: trial subtract and compare.
`default_nettype none
module bsd_div_step (
  input  wire logic [bsd_pkg::WORD_BITS:0]   partial,
  input  wire logic [bsd_pkg::WORD_BITS-1:0] divisor,
  output logic                               ge,
  output logic [bsd_pkg::WORD_BITS-1:0]      diff
);

  logic [bsd_pkg::WORD_BITS:0] trial;

  // Borrow-free subtract means partial >= divisor.
  always_comb begin
    trial = partial - {1'b0, divisor};
    ge    = (partial >= {1'b0, divisor});
    diff  = trial[bsd_pkg::WORD_BITS-1:0];
  end

endmodule
`default_nettype wire

>>> hw/rtl/bsd_divider.sv
// Iterative restoring divider: one quotient bit per cycle.
`default_nettype none
module bsd_divider #(
  parameter int unsigned DIGIT_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [bsd_pkg::WORD_BITS-1:0]      rem_in,
  input  wire logic [DIGIT_BITS-1:0]              digit,
  input  wire logic [bsd_pkg::WORD_BITS-1:0]      divisor,
  output logic [DIGIT_BITS-1:0]                   quot,
  output logic [bsd_pkg::WORD_BITS-1:0]           rem_out,
  output bsd_pkg::div_stat_t                      stat
);

  localparam int unsigned CNT_W = $clog2(DIGIT_BITS + 1);

  logic [bsd_pkg::WORD_BITS-1:0] rem;
  logic [DIGIT_BITS-1:0]         shreg;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;
  logic                          done;

  logic [bsd_pkg::WORD_BITS:0]   partial;
  logic                          ge;
  logic [bsd_pkg::WORD_BITS-1:0] diff;

  // Next dividend bit joins the remainder.
  assign partial = {rem, shreg[DIGIT_BITS-1]};

  bsd_div_step u_step (
    .partial (partial),
    .divisor (divisor),
    .ge      (ge),
    .diff    (diff)
  );

  // Control: bit counter and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIGIT_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out, quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_in;
      shreg <= digit;
    end else if (busy) begin
      rem   <= ge ? diff : partial[bsd_pkg::WORD_BITS-1:0];
      shreg <= (shreg << 1) | DIGIT_BITS'(ge);
    end
  end

  assign quot      = shreg;
  assign rem_out   = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire
